>>> src/bsfr_pkg.sv
// Shared types and constants for the byte-stuffed frame receiver.
// No dependencies; the front, back and top-level files use this package.
package bsfr_pkg;

   localparam int DEF_MAX_FRAME = 64;
   localparam int MIN_FRAME     = 2;
   localparam int CMD_DEPTH     = 2;
   localparam int OUT_DEPTH     = 4;

   localparam logic [7:0] FLAG_RESET = 8'd126;
   localparam logic [7:0] ESC_RESET  = 8'd125;
   localparam logic [7:0] BIT5_MASK  = 8'h20;

   localparam logic CSR_FLAG = 1'b0;
   localparam logic CSR_ESC  = 1'b1;

   typedef enum logic [1:0] {
      PH_WAIT = 2'd0,
      PH_DATA = 2'd1,
      PH_ESC  = 2'd2
   } phase_type;

   typedef enum logic {
      CMD_STORE  = 1'b0,
      CMD_COMMIT = 1'b1
   } cmd_kind_type;

endpackage

>>> src/bsfr_fifo.sv
// Small synchronous queue with registered storage and an occupancy count.
// Depends on nothing; used for the command queue and the result queue.
module bsfr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [WIDTH-1:0]             push_data,
   input  logic                         pop,
   output logic [WIDTH-1:0]             pop_data,
   output logic                         empty,
   output logic                         full,
   output logic [$clog2(DEPTH+1)-1:0]   count
);
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH+1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign count    = count_ff;
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> src/bsfr_front.sv
// Front part: tracks flags and escapes, counts stored bytes and decides
// acceptance at the closing flag. Issues store and commit commands. Uses bsfr_pkg.
module bsfr_front #(
   parameter int MAX_FRAME = bsfr_pkg::DEF_MAX_FRAME
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [7:0]                     flag_byte,
   input  logic [7:0]                     escape_byte,
   input  logic                           in_take,
   input  logic [7:0]                     in_byte,
   output logic                           cmd_push,
   output bsfr_pkg::cmd_kind_type         cmd_kind,
   output logic [7:0]                     cmd_data,
   output logic [$clog2(MAX_FRAME+1)-1:0] cmd_count
);
   import bsfr_pkg::*;

   localparam int CNT_W = $clog2(MAX_FRAME+1);

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [7:0]       first_ff, first_in;
   logic             store_req;
   logic [7:0]       store_val;
   logic             frame_ok;

   assign frame_ok = !ovf_ff && (count_ff >= CNT_W'(MIN_FRAME)) &&
                     (first_ff == 8'(count_ff));

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      first_in  = first_ff;
      store_req = 1'b0;
      store_val = in_byte;
      cmd_push  = 1'b0;
      cmd_kind  = CMD_STORE;
      cmd_data  = in_byte;
      cmd_count = count_ff;
      if (in_take) begin
         case (phase_ff)
            PH_DATA: begin
               if (in_byte == escape_byte) begin
                  phase_in = PH_ESC;
               end else if (in_byte == flag_byte) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  if (frame_ok) begin
                     phase_in = PH_WAIT;
                     cmd_push = 1'b1;
                     cmd_kind = CMD_COMMIT;
                  end else begin
                     // A rejected frame's closing flag opens the next one.
                     phase_in = PH_DATA;
                  end
               end else begin
                  store_req = 1'b1;
               end
            end
            PH_ESC: begin
               phase_in  = PH_DATA;
               store_req = 1'b1;
               store_val = in_byte | BIT5_MASK;
            end
            default: begin
               phase_in = PH_WAIT;
               if (in_byte == flag_byte) begin
                  phase_in = PH_DATA;
                  count_in = '0;
                  ovf_in   = 1'b0;
               end
            end
         endcase
         if (store_req) begin
            if (count_ff < CNT_W'(MAX_FRAME)) begin
               cmd_push = 1'b1;
               cmd_kind = CMD_STORE;
               cmd_data = store_val;
               count_in = count_ff + CNT_W'(1);
               if (count_ff == '0) begin
                  first_in = store_val;
               end
            end else begin
               ovf_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff <= first_in;
   end

endmodule

>>> src/bsfr_back.sv
// Back part: holds the frame store, writes stored bytes and replays a
// committed frame into the result queue. Uses bsfr_pkg and bsfr_fifo.
module bsfr_back #(
   parameter int MAX_FRAME = bsfr_pkg::DEF_MAX_FRAME
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           cmd_empty,
   input  bsfr_pkg::cmd_kind_type         cmd_kind,
   input  logic [7:0]                     cmd_data,
   input  logic [$clog2(MAX_FRAME+1)-1:0] cmd_count,
   output logic                           cmd_pop,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [7:0]                     rsp_frame_byte,
   output logic                           rsp_frame_last
);
   import bsfr_pkg::*;

   localparam int CNT_W     = $clog2(MAX_FRAME+1);
   localparam int ADDR_W    = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH+1);

   logic [7:0]           store_mem [MAX_FRAME];
   logic                 busy_ff, busy_in;
   logic [CNT_W-1:0]     ptr_ff, ptr_in;
   logic [CNT_W-1:0]     len_ff, len_in;
   logic                 rd_valid_ff;
   logic                 rd_last_ff, rd_last_in;
   logic [7:0]           rd_data_ff;
   logic                 issue;
   logic                 space;
   logic                 out_full;
   logic [OUT_CNT_W-1:0] out_count;
   logic [8:0]           out_word;

   // One read may be in flight, so it is counted against the queue's room.
   assign space = (({1'b0, out_count} + (OUT_CNT_W+1)'(rd_valid_ff)) <
                   (OUT_CNT_W+1)'(OUT_DEPTH));
   assign issue   = busy_ff && space;
   assign cmd_pop = !busy_ff && !cmd_empty;

   always_comb begin
      busy_in    = busy_ff;
      ptr_in     = ptr_ff;
      len_in     = len_ff;
      rd_last_in = (ptr_ff + CNT_W'(1)) == len_ff;
      if (cmd_pop && (cmd_kind == CMD_COMMIT)) begin
         busy_in = 1'b1;
         ptr_in  = '0;
         len_in  = cmd_count;
      end else if (issue) begin
         ptr_in = ptr_ff + CNT_W'(1);
         if (rd_last_in) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         rd_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      len_ff <= len_in;
      if (issue) begin
         rd_last_ff <= rd_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop && (cmd_kind == CMD_STORE)) begin
         store_mem[cmd_count[ADDR_W-1:0]] <= cmd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_data_ff <= store_mem[ptr_ff[ADDR_W-1:0]];
      end
   end

   bsfr_fifo #(
      .WIDTH (9),
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rd_valid_ff),
      .push_data ({rd_last_ff, rd_data_ff}),
      .pop       (rsp_pop),
      .pop_data  (out_word),
      .empty     (rsp_empty),
      .full      (out_full),
      .count     (out_count)
   );

   assign rsp_frame_byte = out_word[7:0];
   assign rsp_frame_last = out_word[8] && !out_full || out_word[8];

endmodule

>>> src/byte_stuffed_frame_receiver_core.sv
// Byte-stuffed frame receiver, top level. The front queues an item's command; the
// back takes it once no replay is running. After a commit is taken, an accepted
// frame's first byte passes the busy flag, the read register and the result queue,
// the rest one per cycle while the result side pops. Input stalls only
// while a replay holds the two-entry command queue full. Synchronous active-high
// reset returns to waiting for a flag, empties both queues and loads the defaults.
module byte_stuffed_frame_receiver_core #(
   parameter int MAX_FRAME = bsfr_pkg::DEF_MAX_FRAME
) (
   input  logic       clock,
   input  logic       reset,
   // Input channel: one raw byte from the serial link per item.
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_rx_byte,
   // Result channel: one unstuffed byte of an accepted frame per item.
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_frame_byte,
   output logic       rsp_frame_last,
   // Configuration port.
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);
   import bsfr_pkg::*;

   localparam int CNT_W   = $clog2(MAX_FRAME+1);
   localparam int CMD_W   = 1 + 8 + CNT_W;

   logic [7:0]       flag_ff, escape_ff;
   logic             in_take;
   logic             front_push;
   cmd_kind_type     front_kind;
   logic [7:0]       front_data;
   logic [CNT_W-1:0] front_count;
   logic [CMD_W-1:0] cmd_word;
   logic             cmd_empty, cmd_full, cmd_pop;
   logic [$clog2(CMD_DEPTH+1)-1:0] cmd_level;

   // Configuration registers. They are only to be written while the block is idle; the block does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff   <= FLAG_RESET;
         escape_ff <= ESC_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FLAG: flag_ff   <= csr_wdata;
            CSR_ESC:  escape_ff <= csr_wdata;
            default:  flag_ff   <= flag_ff;
         endcase
      end
   end

   // An item may produce a command, so input is held off while the command
   // queue has no free entry.
   assign req_full = cmd_full;
   assign in_take  = req_push && !cmd_full;

   bsfr_front #(
      .MAX_FRAME (MAX_FRAME)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .flag_byte   (flag_ff),
      .escape_byte (escape_ff),
      .in_take     (in_take),
      .in_byte     (req_rx_byte),
      .cmd_push    (front_push),
      .cmd_kind    (front_kind),
      .cmd_data    (front_data),
      .cmd_count   (front_count)
   );

   // The command queue decouples classification from the store and replay.
   bsfr_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data ({front_kind, front_data, front_count}),
      .pop       (cmd_pop),
      .pop_data  (cmd_word),
      .empty     (cmd_empty),
      .full      (cmd_full),
      .count     (cmd_level)
   );

   bsfr_back #(
      .MAX_FRAME (MAX_FRAME)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_empty      (cmd_empty || (cmd_level == '0)),
      .cmd_kind       (cmd_kind_type'(cmd_word[CMD_W-1])),
      .cmd_data       (cmd_word[CMD_W-2 -: 8]),
      .cmd_count      (cmd_word[CNT_W-1:0]),
      .cmd_pop        (cmd_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule
